[rtl/mrw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrw_pkg
// Shared types for the Miller-Rabin witness round: sequencer states and the
// request and status groups between the sequencer and the modular multiplier.
// ----------------------------------------------------------------------------
package mrw_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT,
        S_POW_SQ,
        S_POW_SQ_WAIT,
        S_POW_MUL,
        S_POW_MUL_WAIT,
        S_EVAL,
        S_LOOP,
        S_SQR_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic start;
    } t_mm_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_status;

endpackage

[rtl/mrw_modmul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mrw_modmul
// Bit-serial interleaved modular multiplier: x * y mod n, one bit of y per
// cycle from the top, with one double-and-add plus reduction per step.
// ----------------------------------------------------------------------------
module mrw_modmul #(
    parameter int WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrw_pkg::t_mm_req    i_req,
    input  logic [WIDTH-1:0]    i_x,
    input  logic [WIDTH-1:0]    i_y,
    input  logic [WIDTH-1:0]    i_n,
    output mrw_pkg::t_mm_status o_status,
    output logic [WIDTH-1:0]    o_result
);
    import mrw_pkg::*;

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] r_x, n_x;
    logic [WIDTH-1:0] r_y, n_y;
    logic [WIDTH-1:0] r_acc, n_acc;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;

    logic [WIDTH+1:0] sum;
    logic [WIDTH+1:0] n_ext;
    logic [WIDTH+1:0] n_twice;
    logic [WIDTH-1:0] step;

    // The accumulator and x are both below n, so the sum stays below 3n.
    assign n_ext   = {2'b00, i_n};
    assign n_twice = {1'b0, i_n, 1'b0};
    assign sum     = {1'b0, r_acc, 1'b0} + (r_y[WIDTH-1] ? {2'b00, r_x} : '0);

    always_comb begin
        if (sum >= n_twice) begin
            step = WIDTH'(sum - n_twice);
        end else if (sum >= n_ext) begin
            step = WIDTH'(sum - n_ext);
        end else begin
            step = sum[WIDTH-1:0];
        end
    end

    always_comb begin
        n_x    = r_x;
        n_y    = r_y;
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start && !r_busy) begin
            n_x    = i_x;
            n_y    = i_y;
            n_acc  = '0;
            n_cnt  = CNT_W'(WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_acc = step;
            n_y   = {r_y[WIDTH-2:0], 1'b0};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_acc <= n_acc;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_result      = r_acc;

    a_no_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.start)
        else $error("multiplier started while busy");

    a_done_after_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a preceding run");

    a_count_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("bit counter ran out while busy");

endmodule

[rtl/miller_rabin_witness_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// miller_rabin_witness_test
// One Miller-Rabin round for candidate n and witness a: split n-1 into
// d * 2^s, raise a to d mod n, then square up to s-1 times looking for n-1.
// ----------------------------------------------------------------------------
// One word is worked on at a time; a new word is taken while the previous
// result still waits in the output register. Every modular product goes
// through a single bit-serial multiplier. A rejected word (n even or below
// 3, witness zero or not below n) goes straight to the output state.
module miller_rabin_witness_test #(
    parameter int WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_candidate,
    input  logic [31:0] i_witness,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_probably_prime,
    output logic        o_bad_input
);
    import mrw_pkg::*;

    localparam int EXT_W   = (WIDTH > 32) ? WIDTH : 32;
    localparam int S_W     = $clog2(WIDTH);
    localparam int BCNT_W  = $clog2(WIDTH + 1);

    t_state r_state, n_state;

    logic [WIDTH-1:0]  r_n, n_n;
    logic [WIDTH-1:0]  r_a, n_a;
    logic [WIDTH-1:0]  r_top, n_top;
    logic [WIDTH-1:0]  r_d, n_d;
    logic [WIDTH-1:0]  r_acc, n_acc;
    logic [S_W-1:0]    r_s, n_s;
    logic [S_W-1:0]    r_rem, n_rem;
    logic [BCNT_W-1:0] r_bits, n_bits;
    logic              r_pass, n_pass;
    logic              r_bad, n_bad;
    logic              r_out_valid, n_out_valid;
    logic              r_out_pp, n_out_pp;
    logic              r_out_bad, n_out_bad;

    logic [EXT_W-1:0]  cand_ext;
    logic [EXT_W-1:0]  wit_ext;
    logic [WIDTH-1:0]  in_n;
    logic [WIDTH-1:0]  in_a;
    logic              in_bad;
    logic              accept;
    logic              out_free;

    t_mm_req           mm_req;
    t_mm_status        mm_status;
    logic [WIDTH-1:0]  mm_op;
    logic [WIDTH-1:0]  mm_result;

    assign cand_ext = EXT_W'(i_candidate);
    assign wit_ext  = EXT_W'(i_witness);
    assign in_n     = cand_ext[WIDTH-1:0];
    assign in_a     = wit_ext[WIDTH-1:0];
    assign in_bad   = (in_n < WIDTH'(3)) || !in_n[0] || (in_a == '0) || (in_a >= in_n);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    mrw_modmul #(
        .WIDTH(WIDTH)
    ) u_modmul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mm_req),
        .i_x      (mm_op),
        .i_y      ((r_state == S_POW_MUL) ? r_acc : mm_op),
        .i_n      (r_n),
        .o_status (mm_status),
        .o_result (mm_result)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = in_bad ? S_FIN : S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (r_d[0]) begin
                    n_state = S_POW_SQ;
                end
            end
            S_POW_SQ: begin
                n_state = S_POW_SQ_WAIT;
            end
            S_POW_SQ_WAIT: begin
                if (mm_status.done) begin
                    if (r_d[WIDTH-1]) begin
                        n_state = S_POW_MUL;
                    end else if (r_bits == BCNT_W'(1)) begin
                        n_state = S_EVAL;
                    end else begin
                        n_state = S_POW_SQ;
                    end
                end
            end
            S_POW_MUL: begin
                n_state = S_POW_MUL_WAIT;
            end
            S_POW_MUL_WAIT: begin
                if (mm_status.done) begin
                    n_state = (r_bits == BCNT_W'(1)) ? S_EVAL : S_POW_SQ;
                end
            end
            S_EVAL: begin
                n_state = (r_acc == WIDTH'(1)) ? S_FIN : S_LOOP;
            end
            S_LOOP: begin
                if ((r_acc == r_top) || (r_rem == '0)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SQR_WAIT;
                end
            end
            S_SQR_WAIT: begin
                if (mm_status.done) begin
                    n_state = S_LOOP;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control outputs.
    always_comb begin
        o_ready      = 1'b0;
        mm_req.start = 1'b0;
        mm_op        = r_acc;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_POW_SQ: begin
                mm_req.start = 1'b1;
            end
            S_POW_MUL: begin
                mm_req.start = 1'b1;
                mm_op        = r_a;
            end
            S_LOOP: begin
                mm_req.start = (r_acc != r_top) && (r_rem != '0);
            end
            default: begin
                mm_req.start = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb begin
        n_n         = r_n;
        n_a         = r_a;
        n_top       = r_top;
        n_d         = r_d;
        n_acc       = r_acc;
        n_s         = r_s;
        n_rem       = r_rem;
        n_bits      = r_bits;
        n_pass      = r_pass;
        n_bad       = r_bad;
        n_out_valid = r_out_valid && !i_ready;
        n_out_pp    = r_out_pp;
        n_out_bad   = r_out_bad;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_n    = in_n;
                    n_a    = in_a;
                    n_top  = in_n - WIDTH'(1);
                    n_d    = in_n - WIDTH'(1);
                    n_s    = '0;
                    n_bad  = in_bad;
                    n_pass = 1'b0;
                end
            end
            S_SPLIT: begin
                if (r_d[0]) begin
                    n_acc  = WIDTH'(1);
                    n_bits = BCNT_W'(WIDTH);
                end else begin
                    n_d = {1'b0, r_d[WIDTH-1:1]};
                    n_s = r_s + S_W'(1);
                end
            end
            S_POW_SQ_WAIT: begin
                if (mm_status.done) begin
                    n_acc = mm_result;
                    // With a set exponent bit the shift waits for the multiply.
                    if (!r_d[WIDTH-1]) begin
                        n_d    = {r_d[WIDTH-2:0], 1'b0};
                        n_bits = r_bits - BCNT_W'(1);
                    end
                end
            end
            S_POW_MUL_WAIT: begin
                if (mm_status.done) begin
                    n_acc  = mm_result;
                    n_d    = {r_d[WIDTH-2:0], 1'b0};
                    n_bits = r_bits - BCNT_W'(1);
                end
            end
            S_EVAL: begin
                n_rem  = r_s - S_W'(1);
                n_pass = (r_acc == WIDTH'(1));
            end
            S_LOOP: begin
                n_pass = (r_acc == r_top);
                if ((r_acc != r_top) && (r_rem != '0)) begin
                    n_rem = r_rem - S_W'(1);
                end
            end
            S_SQR_WAIT: begin
                if (mm_status.done) begin
                    n_acc = mm_result;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pp    = r_pass && !r_bad;
                    n_out_bad   = r_bad;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_n       <= n_n;
        r_a       <= n_a;
        r_top     <= n_top;
        r_d       <= n_d;
        r_acc     <= n_acc;
        r_s       <= n_s;
        r_rem     <= n_rem;
        r_bits    <= n_bits;
        r_pass    <= n_pass;
        r_bad     <= n_bad;
        r_out_pp  <= n_out_pp;
        r_out_bad <= n_out_bad;
    end

    assign o_valid          = r_out_valid;
    assign o_probably_prime = r_out_pp;
    assign o_bad_input      = r_out_bad;

    a_result_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_bad_input && o_probably_prime))
        else $error("a rejected word reported as probably prime");

    a_acc_reduced : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_LOOP) || (r_state == S_EVAL)) |-> (r_acc < r_n))
        else $error("accumulator not reduced modulo n");

    a_mul_idle_when_started : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_req.start |-> !mm_status.busy)
        else $error("multiply requested while the multiplier runs");

    a_split_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_d != '0))
        else $error("exponent became zero while removing factors of two");

endmodule
